### rtl/rsps_pkg.sv
// ----------------------------------------------------------------------------
// rsps_pkg
// Shared constants and pipeline cell payload types for the ray-sphere shader.
// ----------------------------------------------------------------------------
package rsps_pkg;

  localparam int FRAME_COLS = 400;
  localparam int FRAME_ROWS = 225;

  localparam int LEN2_W  = 20;
  localparam int ROOT_W  = 26;
  localparam int SREM_W  = 28;
  localparam int QUO_W   = 18;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = QUO_W;

  localparam logic [19:0] H_SQ = 20'(FRAME_ROWS * FRAME_ROWS);

  typedef struct packed {
    logic              hit;
    logic              yneg;
    logic [8:0]        ay;
    logic [LEN2_W-1:0] vbits;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_word_t;

  typedef struct packed {
    logic             hit;
    logic             yneg;
    logic [ROOT_W-1:0] rem;
    logic [ROOT_W-1:0] divisor;
    logic [QUO_W-1:0] nlow;
    logic [QUO_W-1:0] quo;
  } div_word_t;

endpackage

### rtl/ray_sphere_pixel_shader_unit.sv
// ----------------------------------------------------------------------------
// ray_sphere_pixel_shader_unit
// Per-pixel ray cast against a fixed sphere with a sky gradient on a miss.
// ----------------------------------------------------------------------------
// Accepts one pixel request per clock while the output is not stalled and
// returns one color per request, in order, through one setup stage, 26
// square-root cells, 18 divider cells and the color output register.
// Each stage holds its own request and collapses bubbles, so requests keep
// entering while a result waits at the output.
module ray_sphere_pixel_shader_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // pixel_row[7:0], pixel_column[16:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // red[8:0], green[17:9], blue[26:18]
  output logic        out_tuser   // sphere_hit[0]
);
  import rsps_pkg::*;

  sqrt_word_t sq_word [SQRT_STEPS+1];
  logic       sq_valid [SQRT_STEPS+1];
  logic       sq_ready [SQRT_STEPS+1];
  div_word_t  dv_word [DIV_STEPS+1];
  logic       dv_valid [DIV_STEPS+1];
  logic       dv_ready [DIV_STEPS+1];

  rsps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .row       (in_tdata[7:0]),
    .col       (in_tdata[16:8]),
    .out_valid (sq_valid[0]),
    .out_ready (sq_ready[0]),
    .out_word  (sq_word[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    rsps_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_valid[i]),
      .in_ready  (sq_ready[i]),
      .in_word   (sq_word[i]),
      .out_valid (sq_valid[i+1]),
      .out_ready (sq_ready[i+1]),
      .out_word  (sq_word[i+1])
    );
  end

  logic [ROOT_W-1:0] root_eff;
  logic [40:0]       numer;

  always_comb begin
    root_eff = (sq_word[SQRT_STEPS].root == '0) ? ROOT_W'(1) : sq_word[SQRT_STEPS].root;
    numer    = {sq_word[SQRT_STEPS].ay, 32'(root_eff >> 1)};
    dv_word[0].hit     = sq_word[SQRT_STEPS].hit;
    dv_word[0].yneg    = sq_word[SQRT_STEPS].yneg;
    dv_word[0].rem     = ROOT_W'(numer[40:QUO_W]);
    dv_word[0].divisor = root_eff;
    dv_word[0].nlow    = numer[QUO_W-1:0];
    dv_word[0].quo     = '0;
  end

  assign dv_valid[0]          = sq_valid[SQRT_STEPS];
  assign sq_ready[SQRT_STEPS] = dv_ready[0];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rsps_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_valid[i]),
      .in_ready  (dv_ready[i]),
      .in_word   (dv_word[i]),
      .out_valid (dv_valid[i+1]),
      .out_ready (dv_ready[i+1]),
      .out_word  (dv_word[i+1])
    );
  end

  div_word_t   fin;
  logic [16:0] mag;
  logic [17:0] a2;
  logic [16:0] blend;
  logic [8:0]  red_sub;
  logic [17:0] g_num;
  logic [8:0]  g_t;
  logic [17:0] g_prod;
  logic [8:0]  red_nxt;
  logic [8:0]  green_nxt;
  logic [8:0]  blue_nxt;
  logic        out_adv;
  logic        valid_r;
  logic [8:0]  red_r;
  logic [8:0]  green_r;
  logic [8:0]  blue_r;
  logic        hit_r;

  always_comb begin
    fin     = dv_word[DIV_STEPS];
    mag     = (fin.quo > QUO_W'(65536)) ? 17'd65536 : fin.quo[16:0];
    a2      = fin.yneg ? (18'd65536 - 18'(mag)) : (18'd65536 + 18'(mag));
    blend   = a2[17:1];
    red_sub = 9'((18'(blend) + 18'd256) >> 9);
    g_num   = 18'(blend) + 18'({blend, 1'b0}) + 18'd1280;
    g_t     = g_num[17:9];
    g_prod  = 18'(g_t) * 18'd205;
    if (fin.hit) begin
      red_nxt   = 9'd256;
      green_nxt = 9'd0;
      blue_nxt  = 9'd0;
    end else begin
      red_nxt   = 9'd256 - red_sub;
      green_nxt = 9'd256 - 9'(g_prod[17:10]);
      blue_nxt  = 9'd256;
    end
  end

  assign out_adv              = !valid_r || out_tready;
  assign dv_ready[DIV_STEPS]  = out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_adv) begin
      valid_r <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && dv_valid[DIV_STEPS]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      hit_r   <= fin.hit;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {5'b0, blue_r, green_r, red_r};
  assign out_tuser  = hit_r;

  a_hit_green : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[17:9] == 9'd0 && out_tdata[26:18] == 9'd0)
    else $error("hit result carries green or blue");

  a_miss_blue : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[26:18] == 9'd256)
    else $error("sky result blue not saturated");

  a_ready_idle : assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !sq_valid[0] |-> in_tready)
    else $error("input stalled with empty pipeline head");

endmodule

### rtl/rsps_front.sv
// ----------------------------------------------------------------------------
// rsps_front
// Ray setup: direction components, squared length and sphere hit test.
// ----------------------------------------------------------------------------
module rsps_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           row,
  input  logic [8:0]           col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsps_pkg::sqrt_word_t out_word
);
  import rsps_pkg::*;

  logic              valid_r;
  sqrt_word_t        word_r;
  sqrt_word_t        word_nxt;
  logic signed [11:0] x;
  logic signed [11:0] y;
  logic [9:0]        ax;
  logic [8:0]        ay;
  logic [18:0]       xy2;
  logic [20:0]       xy2_3;

  always_comb begin
    x     = $signed({2'b00, col, 1'b1}) - $signed(12'(FRAME_COLS));
    y     = $signed(12'(FRAME_ROWS - 1)) - $signed({3'b000, row, 1'b0});
    ax    = x[11] ? 10'(-x) : x[9:0];
    ay    = y[11] ? 9'(-y) : y[8:0];
    xy2   = 19'(20'(ax) * 20'(ax)) + 19'(18'(ay) * 18'(ay));
    xy2_3 = 21'(xy2) + {1'b0, xy2, 1'b0};
    word_nxt.hit   = ({1'b0, H_SQ} >= xy2_3);
    word_nxt.yneg  = y[11];
    word_nxt.ay    = ay;
    word_nxt.vbits = LEN2_W'(xy2) + H_SQ;
    word_nxt.rem   = '0;
    word_nxt.root  = '0;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

### rtl/rsps_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsps_sqrt_cell
// One digit step of the restoring square root, registered.
// ----------------------------------------------------------------------------
module rsps_sqrt_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rsps_pkg::sqrt_word_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rsps_pkg::sqrt_word_t out_word
);
  import rsps_pkg::*;

  logic              valid_r;
  sqrt_word_t        word_r;
  sqrt_word_t        word_nxt;
  logic [SREM_W:0]   rem_sh;
  logic [SREM_W:0]   trial;

  always_comb begin
    rem_sh   = {in_word.rem[SREM_W-2:0], in_word.vbits[LEN2_W-1:LEN2_W-2]};
    trial    = {1'b0, in_word.root, 2'b01};
    word_nxt = in_word;
    word_nxt.vbits = {in_word.vbits[LEN2_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      word_nxt.rem  = SREM_W'(rem_sh - trial);
      word_nxt.root = {in_word.root[ROOT_W-2:0], 1'b1};
    end else begin
      word_nxt.rem  = rem_sh[SREM_W-1:0];
      word_nxt.root = {in_word.root[ROOT_W-2:0], 1'b0};
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

### rtl/rsps_div_cell.sv
// ----------------------------------------------------------------------------
// rsps_div_cell
// One quotient bit of the restoring division, registered.
// ----------------------------------------------------------------------------
module rsps_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rsps_pkg::div_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rsps_pkg::div_word_t out_word
);
  import rsps_pkg::*;

  logic            valid_r;
  div_word_t       word_r;
  div_word_t       word_nxt;
  logic [ROOT_W:0] rem_sh;

  always_comb begin
    rem_sh   = {in_word.rem, in_word.nlow[QUO_W-1]};
    word_nxt = in_word;
    word_nxt.nlow = {in_word.nlow[QUO_W-2:0], 1'b0};
    if (rem_sh >= {1'b0, in_word.divisor}) begin
      word_nxt.rem = ROOT_W'(rem_sh - {1'b0, in_word.divisor});
      word_nxt.quo = {in_word.quo[QUO_W-2:0], 1'b1};
    end else begin
      word_nxt.rem = rem_sh[ROOT_W-1:0];
      word_nxt.quo = {in_word.quo[QUO_W-2:0], 1'b0};
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams pixel requests into the ray-sphere shader and checks every color
// against a bit-exact integer predictor, with random idling on both sides,
// a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
  import rsps_pkg::*;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
    logic       hit;
  } color_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  color_t color_queue[$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  bit     hold_output = 1'b0;
  bit     out_idle_on = 1'b1;
  bit     in_idle_on = 1'b1;

  ray_sphere_pixel_shader_unit uut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic color_t shade_pixel(logic [7:0] row, logic [8:0] col);
    color_t          c;
    longint          x;
    longint          y;
    longint          h;
    longint unsigned ax;
    longint unsigned ay;
    longint unsigned xy2;
    longint unsigned s;
    longint unsigned mag;
    longint          dy;
    longint          a;
    longint          g;
    longint          r;
    h = FRAME_ROWS;
    x = 2 * longint'(col) + 1 - FRAME_COLS;
    y = h - 2 * longint'(row) - 1;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    xy2 = ax * ax + ay * ay;
    if (h * h >= 3 * xy2) begin
      c.red = 9'd256;
      c.green = 9'd0;
      c.blue = 9'd0;
      c.hit = 1'b1;
      return c;
    end
    s = isqrt((xy2 + h * h) << 32);
    if (s == 0) s = 1;
    mag = ((ay << 32) + (s >> 1)) / s;
    if (mag > 65536) mag = 65536;
    dy = (y < 0) ? -longint'(mag) : longint'(mag);
    a = (dy + 65536) / 2;
    r = 256 - (a + 256) / 512;
    g = 256 - (3 * a + 1280) / 2560;
    c.red = (r < 0) ? 9'd0 : (r > 256) ? 9'd256 : 9'(r);
    c.green = (g < 0) ? 9'd0 : (g > 256) ? 9'd256 : 9'(g);
    c.blue = 9'd256;
    c.hit = 1'b0;
    return c;
  endfunction

  task automatic send_pixel(logic [7:0] row, logic [8:0] col);
    int gap;
    gap = in_idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    color_queue.push_back(shade_pixel(row, col));
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    release_input();
    while (color_queue.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      color_t want;
      if (color_queue.size() == 0) begin
        $error("unexpected color out_tdata=%h", out_tdata);
        fail_count++;
      end else begin
        want = color_queue.pop_front();
        if (out_tdata[8:0] !== want.red) begin
          $error("red exp %0d got %0d", want.red, out_tdata[8:0]);
          fail_count++;
        end
        if (out_tdata[17:9] !== want.green) begin
          $error("green exp %0d got %0d", want.green, out_tdata[17:9]);
          fail_count++;
        end
        if (out_tdata[26:18] !== want.blue) begin
          $error("blue exp %0d got %0d", want.blue, out_tdata[26:18]);
          fail_count++;
        end
        if (out_tdata[31:27] !== 5'd0) begin
          $error("pad exp 0 got %0d", out_tdata[31:27]);
          fail_count++;
        end
        if (out_tuser !== want.hit) begin
          $error("sphere_hit exp %0d got %0d", want.hit, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // draw a stall length per result
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_tready <= 1'b0;
      end else if (!out_tready || out_tvalid) begin
        stall = out_idle_on ? $urandom_range(0, 4) : 0;
        if (stall > 0 && out_tready) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > 5000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_corners();
    send_pixel(8'd0, 9'd0);
    send_pixel(8'd0, 9'd399);
    send_pixel(8'd224, 9'd0);
    send_pixel(8'd224, 9'd399);
    send_pixel(8'd112, 9'd199);
    send_pixel(8'd112, 9'd200);
    send_pixel(8'd0, 9'd200);
    send_pixel(8'd224, 9'd200);
    send_pixel(8'd112, 9'd0);
    send_pixel(8'd112, 9'd399);
  endtask

  task automatic test_outside_image();
    send_pixel(8'd255, 9'd511);
    send_pixel(8'd255, 9'd0);
    send_pixel(8'd0, 9'd511);
    send_pixel(8'd225, 9'd400);
    send_pixel(8'd170, 9'd170);
    send_pixel(8'd85, 9'd341);
  endtask

  task automatic test_sphere_edge();
    for (int k = 0; k < 6; k++) send_pixel(8'd112, 9'(140 + 24 * k));
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        send_pixel(8'($urandom), 9'($urandom));
      end else begin
        send_pixel(8'($urandom_range(0, 224)), 9'($urandom_range(0, 399)));
      end
    end
  endtask

  task automatic test_backpressure();
    hold_output = 1'b1;
    in_idle_on = 1'b0;
    fork
      begin
        repeat (150) @(posedge clk);
        hold_output = 1'b0;
      end
      test_random(120);
    join
    in_idle_on = 1'b1;
    wait_drained();
  endtask

  task automatic test_streaming();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    test_random(150);
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corners();
    test_outside_image();
    test_sphere_edge();
    test_random(250);
    wait_drained();
    test_backpressure();
    test_streaming();
    test_random(300);
    wait_drained();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
